FILE: sv/i2cmte_pkg.sv
package i2cmte_pkg;

  localparam int unsigned MAX_TRANSFER_BYTES_DEF = 65535;

  localparam int ACTION_W  = 2;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [6:0] SLAVE_ADDR_RST  = 7'h7f;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd200;

  // Hold times are stored as (duration - 1).
  localparam logic [2:0] HOLD_1 = 3'd0;
  localparam logic [2:0] HOLD_2 = 3'd1;
  localparam logic [2:0] HOLD_4 = 3'd3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_BYTE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDR  = 1'b0,
    CFG_ACK_TIMEOUT = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_HI   = 5'd1,
    PH_ST_SDA  = 5'd2,
    PH_WB_LO   = 5'd3,
    PH_WB_HI   = 5'd4,
    PH_WB_END  = 5'd5,
    PH_AK_REL  = 5'd6,
    PH_AK_HI   = 5'd7,
    PH_AK_WAIT = 5'd8,
    PH_NEED    = 5'd9,
    PH_RB_LO   = 5'd10,
    PH_RB_HI   = 5'd11,
    PH_MA_LO   = 5'd12,
    PH_MA_HI   = 5'd13,
    PH_SP_LO   = 5'd14,
    PH_SP_HI   = 5'd15,
    PH_SP_REL  = 5'd16,
    PH_SPF_LO  = 5'd17,
    PH_SPF_HI  = 5'd18,
    PH_SPF_REL = 5'd19
  } phase_t;

  typedef struct packed {
    phase_t               phase;
    logic                 is_read;
    logic [COUNT_W-1:0]   bytes_left;
    logic [7:0]           shift_reg;
    logic [3:0]           bit_index;
    logic [2:0]           wait_ticks;
    logic [7:0]           ack_wait_count;
    logic                 scl_level;
    logic                 sda_level;
  } eng_state_t;

  // Declared from the top bit down so that scl_out lands in bit 0.
  typedef struct packed {
    logic       status;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       need_byte;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

  function automatic eng_state_t go_f(eng_state_t s, phase_t p, logic scl, logic sda,
                                      logic [2:0] hold);
    eng_state_t r;
    r = s;
    r.phase      = p;
    r.scl_level  = scl;
    r.sda_level  = sda;
    r.wait_ticks = hold;
    return r;
  endfunction

  // Step taken once an acknowledge bit has been handled.
  function automatic eng_state_t after_ack_f(eng_state_t s);
    eng_state_t r;
    r = s;
    if (s.bytes_left == '0) begin
      r = go_f(r, PH_SP_LO, 1'b0, 1'b0, HOLD_4);
    end else if (s.is_read) begin
      r.bit_index = '0;
      r.shift_reg = '0;
      r = go_f(r, PH_RB_LO, 1'b0, 1'b1, HOLD_2);
    end else begin
      r = go_f(r, PH_NEED, 1'b0, 1'b1, HOLD_1);
    end
    return r;
  endfunction

endpackage

FILE: sv/i2cmte_core.sv
module i2cmte_core #(
  parameter int unsigned MAX_TRANSFER_BYTES = i2cmte_pkg::MAX_TRANSFER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  i2cmte_pkg::action_t            action,
  input  logic [7:0]                     tx_byte,
  input  logic [i2cmte_pkg::COUNT_W-1:0] byte_count,
  input  logic                           sda_in,
  input  logic [6:0]                     slave_address,
  input  logic [7:0]                     ack_timeout,
  output i2cmte_pkg::result_t            res
);
  import i2cmte_pkg::*;

  // Saturation limit clipped to what the count field can carry.
  localparam logic [COUNT_W-1:0] MAX_CNT =
    (MAX_TRANSFER_BYTES >= (32'd1 << COUNT_W)) ? {COUNT_W{1'b1}}
                                                : MAX_TRANSFER_BYTES[COUNT_W-1:0];

  eng_state_t st_r, st_nxt;
  logic       ev_rx_valid;
  logic [7:0] ev_rx_byte;
  logic       ev_done;
  logic       ev_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, is_read: 1'b0, bytes_left: '0, shift_reg: '0,
                bit_index: '0, wait_ticks: '0, ack_wait_count: '0,
                scl_level: 1'b1, sda_level: 1'b1};
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    eng_state_t         s;
    logic [7:0]         sh;
    logic [3:0]         bi;
    logic [COUNT_W-1:0] cnt;
    s           = st_r;
    sh          = st_r.shift_reg;
    bi          = st_r.bit_index;
    cnt         = (byte_count > MAX_CNT) ? MAX_CNT : byte_count;
    ev_rx_valid = 1'b0;
    ev_rx_byte  = '0;
    ev_done     = 1'b0;
    ev_status   = 1'b0;

    unique case (action)
      ACT_TICK: begin
        if (st_r.phase == PH_IDLE || st_r.phase == PH_NEED) begin
          s = st_r;
        end else if (st_r.phase == PH_AK_WAIT) begin
          if (!sda_in) begin
            s = after_ack_f(st_r);
          end else if (st_r.ack_wait_count >= ack_timeout) begin
            s = go_f(st_r, PH_SPF_LO, 1'b0, 1'b0, HOLD_4);
          end else begin
            s.ack_wait_count = st_r.ack_wait_count + 8'd1;
          end
        end else if (st_r.wait_ticks != '0) begin
          s.wait_ticks = st_r.wait_ticks - 3'd1;
        end else begin
          if (st_r.phase == PH_RB_HI) begin
            sh = {st_r.shift_reg[6:0], sda_in};
            bi = st_r.bit_index + 4'd1;
          end
          s.shift_reg = sh;
          s.bit_index = bi;
          unique case (st_r.phase)
            PH_ST_HI:  s = go_f(s, PH_ST_SDA, 1'b1, 1'b0, HOLD_4);
            PH_ST_SDA: s = go_f(s, PH_WB_LO, 1'b0, sh[7], HOLD_2);
            PH_WB_LO:  s = go_f(s, PH_WB_HI, 1'b1, st_r.sda_level, HOLD_2);
            PH_WB_HI:  s = go_f(s, PH_WB_END, 1'b0, st_r.sda_level, HOLD_2);
            PH_WB_END: begin
              s.shift_reg = {sh[6:0], 1'b0};
              s.bit_index = bi + 4'd1;
              if (s.bit_index >= BITS_PER_BYTE) begin
                s = go_f(s, PH_AK_REL, 1'b0, 1'b1, HOLD_1);
              end else begin
                s = go_f(s, PH_WB_LO, 1'b0, s.shift_reg[7], HOLD_2);
              end
            end
            PH_AK_REL: s = go_f(s, PH_AK_HI, 1'b1, 1'b1, HOLD_1);
            PH_AK_HI: begin
              s.ack_wait_count = '0;
              s = go_f(s, PH_AK_WAIT, 1'b1, 1'b1, HOLD_1);
            end
            PH_RB_LO:  s = go_f(s, PH_RB_HI, 1'b1, 1'b1, HOLD_2);
            PH_RB_HI: begin
              if (bi >= BITS_PER_BYTE) begin
                // The last byte of a read gets a NACK (SDA released).
                ev_rx_valid  = 1'b1;
                ev_rx_byte   = sh;
                s.bytes_left = st_r.bytes_left - 1'b1;
                s = go_f(s, PH_MA_LO, 1'b0, !(st_r.bytes_left > 1), HOLD_2);
              end else begin
                s = go_f(s, PH_RB_LO, 1'b0, 1'b1, HOLD_2);
              end
            end
            PH_MA_LO:  s = go_f(s, PH_MA_HI, 1'b1, st_r.sda_level, HOLD_2);
            PH_MA_HI:  s = after_ack_f(s);
            PH_SP_LO:  s = go_f(s, PH_SP_HI, 1'b1, 1'b0, HOLD_4);
            PH_SP_HI:  s = go_f(s, PH_SP_REL, 1'b1, 1'b1, HOLD_4);
            PH_SP_REL: begin
              s = go_f(s, PH_IDLE, 1'b1, 1'b1, HOLD_1);
              ev_done = 1'b1;
            end
            PH_SPF_LO: s = go_f(s, PH_SPF_HI, 1'b1, 1'b0, HOLD_4);
            PH_SPF_HI: s = go_f(s, PH_SPF_REL, 1'b1, 1'b1, HOLD_4);
            PH_SPF_REL: begin
              s = go_f(s, PH_IDLE, 1'b1, 1'b1, HOLD_1);
              ev_done   = 1'b1;
              ev_status = 1'b1;
            end
            default:   s = go_f(s, PH_IDLE, 1'b1, 1'b1, HOLD_1);
          endcase
        end
      end
      ACT_BYTE: begin
        if (st_r.phase == PH_NEED) begin
          s.shift_reg  = tx_byte;
          s.bit_index  = '0;
          s.bytes_left = st_r.bytes_left - 1'b1;
          s = go_f(s, PH_WB_LO, 1'b0, tx_byte[7], HOLD_2);
        end
      end
      ACT_WRITE, ACT_READ: begin
        if (st_r.phase == PH_IDLE) begin
          s.is_read        = (action == ACT_READ);
          s.bytes_left     = cnt;
          s.shift_reg      = {slave_address, action == ACT_READ};
          s.bit_index      = '0;
          s.ack_wait_count = '0;
          s = go_f(s, PH_ST_HI, 1'b1, 1'b1, HOLD_4);
        end
      end
    endcase
    st_nxt = s;
  end

  assign res = '{status: ev_status, done_res: ev_done, rx_byte: ev_rx_byte,
                 rx_valid: ev_rx_valid, need_byte: (st_nxt.phase == PH_NEED),
                 busy_res: (st_nxt.phase != PH_IDLE), sda_out: st_nxt.sda_level,
                 scl_out: st_nxt.scl_level};

  a_begin_starts: assert property (@(posedge clk) disable iff (!rst_n)
    step && st_r.phase == PH_IDLE && (action == ACT_WRITE || action == ACT_READ)
    |=> st_r.phase == PH_ST_HI && st_r.scl_level && st_r.sda_level)
    else $error("begin command from idle did not enter the start phase");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_IDLE || st_r.phase == PH_NEED |-> st_r.wait_ticks == '0)
    else $error("hold counter left running in a waiting phase");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> st_r.phase == PH_IDLE && st_r.scl_level && st_r.sda_level)
    else $error("transfer reported done without releasing the bus");

endmodule

FILE: sv/i2c_master_transfer_engine.sv
// Channel   Direction  Handshake                 Payload
// in_       slave      in_tvalid / in_tready     tuser: action; tdata: tx_byte, byte_count,
//                                                sda_in
// out_      master     out_tvalid / out_tready   tdata: one result word per input word
// cfg_      slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Every input word is either a one-microsecond tick or a command, and each one advances
// the bus state machine by exactly one step in the cycle it is accepted, so one word is
// taken per clock while the skid register is empty; its result is registered on accept.
// The output stage is a register plus a one-word skid register; input is refused only
// while the skid register is full. Reset (rst_n low, synchronous) returns the bus to
// idle with both lines released and the configuration registers to their defaults.
// Configuration writes are always taken and must only happen while the engine is idle.
module i2c_master_transfer_engine #(
  parameter int unsigned MAX_TRANSFER_BYTES = i2cmte_pkg::MAX_TRANSFER_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2cmte_pkg::IN_DATA_W-1:0]  in_tdata,   // tx_byte, byte_count, sda_in
  input  logic [i2cmte_pkg::ACTION_W-1:0]   in_tuser,   // action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // scl_out, sda_out, busy_res, need_byte, rx_valid, rx_byte, done_res, status
  output logic [i2cmte_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i2cmte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cmte_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import i2cmte_pkg::*;

  logic [6:0] slave_address_r;
  logic [7:0] ack_timeout_r;
  logic       in_acc;
  logic       out_acc;
  result_t    res;
  result_t    out_data_r;
  result_t    skid_data_r;
  logic       out_valid_r;
  logic       skid_valid_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= SLAVE_ADDR_RST;
      ack_timeout_r   <= ACK_TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SLAVE_ADDR:  slave_address_r <= cfg_data[6:0];
        CFG_ACK_TIMEOUT: ack_timeout_r   <= cfg_data;
      endcase
    end
  end

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;

  // The engine state moves on every accepted word; the result is captured below.
  i2cmte_core #(
    .MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_acc),
    .action       (action_t'(in_tuser)),
    .tx_byte      (in_tdata[7:0]),
    .byte_count   (in_tdata[23:8]),
    .sda_in       (in_tdata[24]),
    .slave_address(slave_address_r),
    .ack_timeout  (ack_timeout_r),
    .res          (res)
  );

  // Output register with a skid register behind it. When the skid register holds a
  // word, input is held off and that word moves forward as soon as the output drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_acc) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_acc) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_acc) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_acc) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_data_r};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output register is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && out_valid_r && !out_tready |=> skid_valid_r)
    else $error("word accepted during an output stall was not kept");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_tready |=> !skid_valid_r && out_valid_r)
    else $error("skid register did not move forward when the output drained");

endmodule
